FILE: src/bfs_pkg.sv
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared widths, datapath operation codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package bfs_pkg;

    localparam int NODE_W         = 5;   // node field width on the ports
    localparam int NODE_COUNT_DEF = 32;  // default node count
    localparam int IN_TDATA_W     = 24;  // 17 payload bits padded to bytes
    localparam int OUT_TDATA_W    = 8;   // 5 payload bits padded to bytes

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ADJ_RD_A,
        OP_ADJ_WR_A,
        OP_ADJ_RD_B,
        OP_ADJ_WR_B,
        OP_LEG_INIT,
        OP_POP,
        OP_ROW_RD,
        OP_SCAN_LOAD,
        OP_SCAN_STEP,
        OP_BT_INIT,
        OP_BT_STEP,
        OP_WR_INIT,
        OP_WR_STEP,
        OP_LEG_DONE,
        OP_EMIT_INIT,
        OP_EMIT_RD,
        OP_EMIT_LOAD,
        OP_NF_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   second_leg;
    } dp_cmd_t;

    typedef struct packed {
        logic is_add;
        logic query_ok;
        logic use_via;
        logic q_empty;
        logic hit;
        logic fresh_zero;
        logic bt_done;
        logic wr_last;
        logic emit_last;
        logic out_busy;
    } dp_status_t;

endpackage

FILE: src/bfs_datapath.sv
// ----------------------------------------------------------------------------
// bfs_datapath
// Adjacency memory, search queue, parent table, route buffer and output reg.
// ----------------------------------------------------------------------------
module bfs_datapath #(
    parameter int NODE_COUNT = bfs_pkg::NODE_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bfs_pkg::dp_cmd_t                 cmd,
    output bfs_pkg::dp_status_t              status,
    input  logic [bfs_pkg::IN_TDATA_W-1:0]   in_tdata,
    input  logic                             in_tuser,
    input  logic                             cfg_wen,
    input  logic                             cfg_wdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bfs_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                             m_tuser,
    output logic                             m_tlast
);

    localparam int IDX_W  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int ROWS   = 2 << IDX_W;
    localparam int RB_W   = IDX_W + 1;
    localparam int RB_D   = 2 * NODE_COUNT;
    localparam int NW     = bfs_pkg::NODE_W;
    localparam int OUT_TDATA_W_PAD = bfs_pkg::OUT_TDATA_W;
    localparam logic [NW:0]    NC_NODE = (NW+1)'(NODE_COUNT);
    localparam logic [IDX_W:0] NC_Q    = (IDX_W+1)'(NODE_COUNT);
    localparam logic [RB_W-1:0] NC_RB  = RB_W'(NODE_COUNT);

    // item fields
    logic          action_reg, egraph_reg, usevia_reg, mode_reg;
    logic [NW-1:0] a_reg, b_reg, via_reg;

    logic [NODE_COUNT-1:0] adj_mem [ROWS];
    logic [ROWS-1:0]       adj_vld_reg;
    logic [IDX_W-1:0]      queue_mem  [NODE_COUNT];
    logic [IDX_W-1:0]      parent_mem [NODE_COUNT];
    logic [IDX_W-1:0]      rb_mem     [RB_D];

    logic [NODE_COUNT-1:0] rd_row_reg, visited_reg, fresh_reg;
    logic                  rd_vld_reg;
    logic [IDX_W-1:0]      s_reg, t_reg, cur_reg, at_reg, rb_q_reg;
    logic [IDX_W:0]        head_reg, tail_reg;
    logic [RB_W-1:0]       n_reg, pos_reg, wpos_reg, k_reg, total_reg;
    logic [NW-1:0]         out_node_reg;
    logic                  out_found_reg, out_last_reg, out_valid_reg;

    logic                  edge_ok, query_ok;
    logic [IDX_W-1:0]      a_idx, b_idx, via_idx, low_idx, s_new;
    logic [IDX_W:0]        adj_addr;
    logic [NODE_COUNT-1:0] row_cur, lowbit, adj_wdata;
    logic                  adj_we;

    assign a_idx   = a_reg[IDX_W-1:0];
    assign b_idx   = b_reg[IDX_W-1:0];
    assign via_idx = via_reg[IDX_W-1:0];
    assign edge_ok  = ({1'b0, a_reg} < NC_NODE) && ({1'b0, b_reg} < NC_NODE);
    assign query_ok = edge_ok && (!usevia_reg || ({1'b0, via_reg} < NC_NODE));
    assign row_cur  = rd_vld_reg ? rd_row_reg : '0;
    assign lowbit   = fresh_reg & (~fresh_reg + 1'b1);
    assign s_new    = cmd.second_leg ? via_idx : a_idx;

    always_comb
    begin
        low_idx = '0;
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            if (lowbit[i])
            begin
                low_idx = low_idx | IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        case (cmd.op)
            bfs_pkg::OP_ADJ_RD_A, bfs_pkg::OP_ADJ_WR_A:
            begin
                adj_addr  = {egraph_reg, a_idx};
                adj_wdata = row_cur | (NODE_COUNT'(1) << b_idx);
            end
            bfs_pkg::OP_ADJ_RD_B, bfs_pkg::OP_ADJ_WR_B:
            begin
                adj_addr  = {egraph_reg, b_idx};
                adj_wdata = row_cur | (NODE_COUNT'(1) << a_idx);
            end
            default:
            begin
                adj_addr  = {mode_reg, cur_reg};
                adj_wdata = row_cur;
            end
        endcase
    end

    assign adj_we = edge_ok &&
                    ((cmd.op == bfs_pkg::OP_ADJ_WR_A) || (cmd.op == bfs_pkg::OP_ADJ_WR_B));

    // adjacency memory
    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_addr] <= adj_wdata;
        end
        if ((cmd.op == bfs_pkg::OP_ADJ_RD_A) || (cmd.op == bfs_pkg::OP_ADJ_RD_B) ||
            (cmd.op == bfs_pkg::OP_ROW_RD))
        begin
            rd_row_reg <= adj_mem[adj_addr];
            rd_vld_reg <= adj_vld_reg[adj_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adj_vld_reg <= '0;
            mode_reg    <= 1'b0;
        end
        else
        begin
            if (adj_we)
            begin
                adj_vld_reg[adj_addr] <= 1'b1;
            end
            if (cfg_wen)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    // queue, parent table and route buffer
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            bfs_pkg::OP_LEG_INIT:
            begin
                queue_mem[0] <= s_new;
            end
            bfs_pkg::OP_SCAN_STEP:
            begin
                parent_mem[low_idx] <= cur_reg;
                if (tail_reg < NC_Q)
                begin
                    queue_mem[tail_reg[IDX_W-1:0]] <= low_idx;
                end
            end
            bfs_pkg::OP_WR_STEP:
            begin
                rb_mem[wpos_reg] <= at_reg;
            end
            bfs_pkg::OP_EMIT_RD:
            begin
                rb_q_reg <= rb_mem[k_reg];
            end
            default:
            begin
            end
        endcase
    end

    // search registers (payload, no reset)
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            bfs_pkg::OP_LOAD:
            begin
                action_reg <= in_tuser;
                egraph_reg <= in_tdata[0];
                a_reg      <= in_tdata[5:1];
                b_reg      <= in_tdata[10:6];
                usevia_reg <= in_tdata[11];
                via_reg    <= in_tdata[16:12];
            end
            bfs_pkg::OP_LEG_INIT:
            begin
                s_reg       <= s_new;
                t_reg       <= (cmd.second_leg || !usevia_reg) ? b_idx : via_idx;
                pos_reg     <= cmd.second_leg ? total_reg - 1'b1 : '0;
                visited_reg <= NODE_COUNT'(1) << s_new;
                head_reg    <= '0;
                tail_reg    <= (IDX_W+1)'(1);
            end
            bfs_pkg::OP_POP:
            begin
                cur_reg  <= queue_mem[head_reg[IDX_W-1:0]];
                head_reg <= head_reg + 1'b1;
            end
            bfs_pkg::OP_SCAN_LOAD:
            begin
                fresh_reg <= row_cur & ~visited_reg;
            end
            bfs_pkg::OP_SCAN_STEP:
            begin
                visited_reg <= visited_reg | lowbit;
                fresh_reg   <= fresh_reg & ~lowbit;
                if (tail_reg < NC_Q)
                begin
                    tail_reg <= tail_reg + 1'b1;
                end
            end
            bfs_pkg::OP_BT_INIT:
            begin
                at_reg <= t_reg;
                n_reg  <= RB_W'(1);
            end
            bfs_pkg::OP_BT_STEP:
            begin
                at_reg <= parent_mem[at_reg];
                n_reg  <= n_reg + 1'b1;
            end
            bfs_pkg::OP_WR_INIT:
            begin
                at_reg   <= t_reg;
                k_reg    <= '0;
                wpos_reg <= pos_reg + n_reg - 1'b1;
            end
            bfs_pkg::OP_WR_STEP:
            begin
                at_reg   <= parent_mem[at_reg];
                wpos_reg <= wpos_reg - 1'b1;
                k_reg    <= k_reg + 1'b1;
            end
            bfs_pkg::OP_LEG_DONE:
            begin
                total_reg <= pos_reg + n_reg;
            end
            bfs_pkg::OP_EMIT_INIT:
            begin
                k_reg <= '0;
            end
            bfs_pkg::OP_EMIT_LOAD:
            begin
                k_reg <= k_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.op == bfs_pkg::OP_EMIT_LOAD)
        begin
            out_node_reg  <= NW'(rb_q_reg);
            out_found_reg <= 1'b1;
            out_last_reg  <= status.emit_last;
        end
        else if (cmd.op == bfs_pkg::OP_NF_LOAD)
        begin
            out_node_reg  <= '0;
            out_found_reg <= 1'b0;
            out_last_reg  <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.op == bfs_pkg::OP_EMIT_LOAD) || (cmd.op == bfs_pkg::OP_NF_LOAD))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W_PAD'(out_node_reg);
    assign m_tuser  = out_found_reg;
    assign m_tlast  = out_last_reg;

    assign status.is_add     = !action_reg;
    assign status.query_ok   = query_ok;
    assign status.use_via    = usevia_reg;
    assign status.q_empty    = (head_reg == tail_reg);
    assign status.hit        = (cur_reg == t_reg);
    assign status.fresh_zero = (fresh_reg == '0);
    assign status.bt_done    = (at_reg == s_reg) || (n_reg >= NC_RB);
    assign status.wr_last    = (k_reg == n_reg - 1'b1);
    assign status.emit_last  = ((k_reg + 1'b1) == total_reg);
    assign status.out_busy   = out_valid_reg;

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.op == bfs_pkg::OP_EMIT_LOAD) || (cmd.op == bfs_pkg::OP_NF_LOAD))
        |-> !out_valid_reg)
        else $error("result loaded while output busy");

    // a dequeue never passes the tail
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == bfs_pkg::OP_POP) |-> (head_reg != tail_reg))
        else $error("dequeue from empty queue");

    // not-found result is always the single last one with node zero
    a_notfound_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> (out_last_reg && (out_node_reg == '0)))
        else $error("malformed not-found result");

endmodule

FILE: src/bfs_controller.sv
// ----------------------------------------------------------------------------
// bfs_controller
// Sequencer for edge insertion, search legs, path backtrack and emission.
// ----------------------------------------------------------------------------
module bfs_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  bfs_pkg::dp_status_t status,
    output bfs_pkg::dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADD_WA,
        ST_ADD_RB,
        ST_ADD_WB,
        ST_LEG2,
        ST_POP,
        ST_CHECK,
        ST_SCAN_LD,
        ST_SCAN,
        ST_BT_INIT,
        ST_BT,
        ST_WR,
        ST_LEG_END,
        ST_EMIT_INIT,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_NF
    } state_t;

    state_t state_reg, state_next;
    logic   second_reg, second_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        second_next    = second_reg;
        cmd.second_leg = second_reg;
        cmd.op         = bfs_pkg::OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op      = bfs_pkg::OP_LOAD;
                    second_next = 1'b0;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.is_add)
                begin
                    cmd.op     = bfs_pkg::OP_ADJ_RD_A;
                    state_next = ST_ADD_WA;
                end
                else if (!status.query_ok)
                begin
                    state_next = ST_NF;
                end
                else
                begin
                    cmd.op     = bfs_pkg::OP_LEG_INIT;
                    state_next = ST_POP;
                end
            end
            ST_ADD_WA:
            begin
                cmd.op     = bfs_pkg::OP_ADJ_WR_A;
                state_next = ST_ADD_RB;
            end
            ST_ADD_RB:
            begin
                cmd.op     = bfs_pkg::OP_ADJ_RD_B;
                state_next = ST_ADD_WB;
            end
            ST_ADD_WB:
            begin
                cmd.op     = bfs_pkg::OP_ADJ_WR_B;
                state_next = ST_IDLE;
            end
            ST_LEG2:
            begin
                cmd.op     = bfs_pkg::OP_LEG_INIT;
                state_next = ST_POP;
            end
            ST_POP:
            begin
                if (status.q_empty)
                begin
                    state_next = ST_NF;
                end
                else
                begin
                    cmd.op     = bfs_pkg::OP_POP;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.hit)
                begin
                    state_next = ST_BT_INIT;
                end
                else
                begin
                    cmd.op     = bfs_pkg::OP_ROW_RD;
                    state_next = ST_SCAN_LD;
                end
            end
            ST_SCAN_LD:
            begin
                cmd.op     = bfs_pkg::OP_SCAN_LOAD;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (status.fresh_zero)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    cmd.op = bfs_pkg::OP_SCAN_STEP;
                end
            end
            ST_BT_INIT:
            begin
                cmd.op     = bfs_pkg::OP_BT_INIT;
                state_next = ST_BT;
            end
            ST_BT:
            begin
                if (status.bt_done)
                begin
                    cmd.op     = bfs_pkg::OP_WR_INIT;
                    state_next = ST_WR;
                end
                else
                begin
                    cmd.op = bfs_pkg::OP_BT_STEP;
                end
            end
            ST_WR:
            begin
                cmd.op = bfs_pkg::OP_WR_STEP;
                if (status.wr_last)
                begin
                    state_next = ST_LEG_END;
                end
            end
            ST_LEG_END:
            begin
                cmd.op = bfs_pkg::OP_LEG_DONE;
                if (status.use_via && !second_reg)
                begin
                    second_next = 1'b1;
                    state_next  = ST_LEG2;
                end
                else
                begin
                    state_next = ST_EMIT_INIT;
                end
            end
            ST_EMIT_INIT:
            begin
                cmd.op     = bfs_pkg::OP_EMIT_INIT;
                state_next = ST_EMIT_RD;
            end
            ST_EMIT_RD:
            begin
                cmd.op     = bfs_pkg::OP_EMIT_RD;
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = bfs_pkg::OP_EMIT_LOAD;
                    state_next = status.emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_NF:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = bfs_pkg::OP_NF_LOAD;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

    // second leg only ever runs for a stopover query
    a_leg2_via: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEG2) |-> (second_reg && status.use_via))
        else $error("second leg without stopover");

    // input is taken only from idle, and a load always moves on to decode
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == bfs_pkg::OP_LOAD) |=> (state_reg == ST_DECODE))
        else $error("load did not decode");

    // a stored edge write always follows its row read
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD_WA) |-> ($past(state_reg) == ST_DECODE))
        else $error("edge write without row read");

endmodule

FILE: src/bfs_shortest_route_finder.sv
// ----------------------------------------------------------------------------
// bfs_shortest_route_finder
// Breadth-first shortest route over two undirected graphs (walk, drive).
//
//  channel | dir | handshake        | payload
//  s_*     | in  | s_tvalid/tready  | tuser action; tdata graph,a,b,use_via,via
//  m_*     | out | m_tvalid/tready  | tdata route_node; tuser found; tlast last
//  cfg_*   | in  | cfg_wen          | cfg_wdata travel_mode
//
// Sequence: an add reads and writes the row of each end in turn. A query pops
// each node, reads its row and finds new nodes by a one-bit-per-cycle row scan,
// then backtracks the route and writes it to the buffer, and emits each result
// from there. The adjacency memory's single port sets the pace.
// Reset: adjacency rows read as empty through per-row valid bits, no sweep.
// Stalls: m_tready low holds the output register and the emitting sequencer;
// a new item is taken only when the sequencer is back at idle.
// ----------------------------------------------------------------------------
module bfs_shortest_route_finder #(
    parameter int NODE_COUNT = bfs_pkg::NODE_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // edge_graph[0], node_a[5:1], node_b[10:6], use_via[11], via_node[16:12]
    input  logic [bfs_pkg::IN_TDATA_W-1:0]  s_tdata,
    // action[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // route_node[4:0]
    output logic [bfs_pkg::OUT_TDATA_W-1:0] m_tdata,
    // found[0]
    output logic                            m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_wen,
    input  logic                            cfg_wdata
);

    bfs_pkg::dp_cmd_t    cmd;
    bfs_pkg::dp_status_t status;

    // sequencer: one transfer in, then runs the item to completion
    bfs_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // storage and search registers, output register feeds the m_* transfer
    bfs_datapath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_tdata  (s_tdata),
        .in_tuser  (s_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
